// ----- sv/pfd_pkg.sv -----
// ----------------------------------------------------------------------------
// pfd_pkg
// Shared types, widths and constants of the filtered-derivative PID drive.
// ----------------------------------------------------------------------------
package pfd_pkg;

  // fixed-point format of the coefficients and of the controller output
  localparam int COEFF_FRAC_BITS = 16;
  localparam int COEFF_W         = 32;
  localparam int Y_W             = 48;

  // field widths
  localparam int ANGLE_W  = 9;
  localparam int ERR_W    = ANGLE_W + 1;
  localparam int PWM_W    = 12;
  localparam int CV_W     = 32;
  localparam int DIR_W    = 2;

  // duty map
  localparam int DUTY_FULL_SCALE = 4095;
  localparam int DUTY_W          = $clog2(DUTY_FULL_SCALE + 1);
  localparam int DIFF_W          = PWM_W + 1;
  localparam int MAP_X_W         = DUTY_W + PWM_W;
  localparam int RECIP_W         = PWM_W + 2;
  localparam logic [RECIP_W-1:0] DUTY_RECIP =
    RECIP_W'((64'd1 << MAP_X_W) / DUTY_FULL_SCALE);

  // accumulator widths
  localparam int BPROD_W = COEFF_W + ERR_W;
  localparam int FWD_W   = BPROD_W + 2;
  localparam int APROD_W = COEFF_W + Y_W;
  localparam int FB_W    = APROD_W + 1;
  localparam int ACC_W   = FB_W + 1;
  localparam int IP_W    = Y_W + 1;

  localparam logic signed [Y_W-1:0] Y_MAX = {1'b0, {(Y_W-1){1'b1}}};
  localparam logic signed [Y_W-1:0] Y_MIN = {1'b1, {(Y_W-1){1'b0}}};

  // configuration port
  localparam int REG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SETPOINT = 3'd0,
    REG_COEFF_B0 = 3'd1,
    REG_COEFF_B1 = 3'd2,
    REG_COEFF_B2 = 3'd3,
    REG_COEFF_A1 = 3'd4,
    REG_COEFF_A2 = 3'd5,
    REG_PWM_MIN  = 3'd6,
    REG_PWM_MAX  = 3'd7
  } reg_idx_t;

  // reset values: Q16.16 encodings of the PID gains with derivative filter
  localparam logic [ANGLE_W-1:0]        SETPOINT_RST = 9'd150;
  localparam logic signed [COEFF_W-1:0] COEFF_B0_RST = -32'sd924582111;
  localparam logic signed [COEFF_W-1:0] COEFF_B1_RST = 32'sd1825426329;
  localparam logic signed [COEFF_W-1:0] COEFF_B2_RST = -32'sd900844218;
  localparam logic signed [COEFF_W-1:0] COEFF_A1_RST = -32'sd124041;
  localparam logic signed [COEFF_W-1:0] COEFF_A2_RST = 32'sd58505;
  localparam logic [PWM_W-1:0]          PWM_MIN_RST  = 12'd2457;
  localparam logic [PWM_W-1:0]          PWM_MAX_RST  = 12'd4095;

  typedef enum logic [DIR_W-1:0] {
    DIR_KEEP = 2'd0,
    DIR_CW   = 2'd1,
    DIR_CCW  = 2'd2
  } dir_t;

  typedef struct packed {
    logic [ANGLE_W-1:0]        setpoint;
    logic signed [COEFF_W-1:0] b0;
    logic signed [COEFF_W-1:0] b1;
    logic signed [COEFF_W-1:0] b2;
    logic signed [COEFF_W-1:0] a1;
    logic signed [COEFF_W-1:0] a2;
    logic [PWM_W-1:0]          pwm_min;
    logic [PWM_W-1:0]          pwm_max;
  } cfg_t;

  // coefficient times a 48-bit output sample, as two partial products
  function automatic logic signed [APROD_W-1:0] coeff_mul_y(
    input logic signed [COEFF_W-1:0] c,
    input logic signed [Y_W-1:0]     y
  );
    logic signed [Y_W-32-1:0]       y_hi;
    logic signed [32:0]             y_lo;
    logic signed [COEFF_W+Y_W-32-1:0] p_hi;
    logic signed [COEFF_W+33-1:0]   p_lo;
    y_hi = y[Y_W-1:32];
    y_lo = $signed({1'b0, y[31:0]});
    p_hi = c * y_hi;
    p_lo = c * y_lo;
    return (APROD_W'(p_hi) <<< 32) + APROD_W'(p_lo);
  endfunction

endpackage

// ----- sv/pfd_if.sv -----
// ----------------------------------------------------------------------------
// pfd_if
// Valid/ready channels of the PID drive: angle samples in, drive words out.
// ----------------------------------------------------------------------------
interface pfd_in_if import pfd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] angle;

  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

interface pfd_out_if import pfd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  dir_t                   direction;
  logic [PWM_W-1:0]       duty;
  logic signed [CV_W-1:0] control_value;

  modport source (output valid, output direction, output duty, output control_value,
                  input ready);
  modport sink   (input valid, input direction, input duty, input control_value,
                  output ready);
endinterface

// ----- sv/pid_filtered_derivative_motor_drive_top.sv -----
// ----------------------------------------------------------------------------
// pid_filtered_derivative_motor_drive_top
// Discrete PID with filtered derivative: angle in, direction / duty out.
//
//   channel   dir  handshake          payload
//   in_ch     in   valid / ready      angle
//   out_ch    out  valid / ready      direction, duty, control_value
//   cfg_*     in   cfg_we (no ready)  cfg_index, cfg_wdata
//
// One sample per cycle sustained while out_ch.ready holds; the input transfer
// loads the input register, then the difference equation, duty product,
// reciprocal multiply and result register stages each register it in turn.
// The rate is set by the output feedback through the a1/a2 products from
// the y1/y2 delay lines. Reset clears the delay lines and loads the default
// gains. Each stage holds when the one after it is full and stalled, so
// bubbles are squeezed out.
// ----------------------------------------------------------------------------
module pid_filtered_derivative_motor_drive_top import pfd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  pfd_in_if.sink                in_ch,
  pfd_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t                  cfg;
  logic                  y_valid;
  logic                  y_ready;
  logic signed [Y_W-1:0] y_value;

  pfd_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pfd_loop u_loop (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_angle (in_ch.angle),
    .y_valid  (y_valid),
    .y_ready  (y_ready),
    .y_value  (y_value)
  );

  pfd_duty_map u_duty_map (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .y_valid           (y_valid),
    .y_ready           (y_ready),
    .y_value           (y_value),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_direction     (out_ch.direction),
    .out_duty          (out_ch.duty),
    .out_control_value (out_ch.control_value)
  );

endmodule

// ----- sv/pfd_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// pfd_cfg_regs
// Configuration register file: setpoint, filter coefficients and PWM range.
// ----------------------------------------------------------------------------
module pfd_cfg_regs import pfd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SETPOINT: cfg_nxt.setpoint = cfg_wdata[ANGLE_W-1:0];
        REG_COEFF_B0: cfg_nxt.b0       = $signed(cfg_wdata[COEFF_W-1:0]);
        REG_COEFF_B1: cfg_nxt.b1       = $signed(cfg_wdata[COEFF_W-1:0]);
        REG_COEFF_B2: cfg_nxt.b2       = $signed(cfg_wdata[COEFF_W-1:0]);
        REG_COEFF_A1: cfg_nxt.a1       = $signed(cfg_wdata[COEFF_W-1:0]);
        REG_COEFF_A2: cfg_nxt.a2       = $signed(cfg_wdata[COEFF_W-1:0]);
        REG_PWM_MIN:  cfg_nxt.pwm_min  = cfg_wdata[PWM_W-1:0];
        REG_PWM_MAX:  cfg_nxt.pwm_max  = cfg_wdata[PWM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint <= SETPOINT_RST;
      cfg_r.b0       <= COEFF_B0_RST;
      cfg_r.b1       <= COEFF_B1_RST;
      cfg_r.b2       <= COEFF_B2_RST;
      cfg_r.a1       <= COEFF_A1_RST;
      cfg_r.a2       <= COEFF_A2_RST;
      cfg_r.pwm_min  <= PWM_MIN_RST;
      cfg_r.pwm_max  <= PWM_MAX_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- sv/pfd_loop.sv -----
// ----------------------------------------------------------------------------
// pfd_loop
// Input register and the second-order difference equation with its delay
// lines; produces the saturated Q32.16 controller output per sample.
// ----------------------------------------------------------------------------
module pfd_loop import pfd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ANGLE_W-1:0]    in_angle,
  output logic                  y_valid,
  input  logic                  y_ready,
  output logic signed [Y_W-1:0] y_value
);

  logic                  in_valid_r;
  logic [ANGLE_W-1:0]    angle_r;
  logic                  y_valid_r;
  logic signed [Y_W-1:0] y_r;

  logic signed [ERR_W-1:0] e1_r, e2_r;
  logic signed [Y_W-1:0]   y1_r, y2_r;

  logic en_in, en_y;

  logic signed [ERR_W-1:0]   e0;
  logic signed [BPROD_W-1:0] pb0, pb1, pb2;
  logic signed [FWD_W-1:0]   fwd;
  logic signed [APROD_W-1:0] pa1, pa2;
  logic signed [FB_W-1:0]    fb;
  logic signed [ACC_W-1:0]   tot;
  logic signed [Y_W-1:0]     y_nxt;

  assign en_y     = !y_valid_r || y_ready;
  assign en_in    = !in_valid_r || en_y;
  assign in_ready = en_in;

  // feed-forward terms are exact products of integer errors
  assign e0  = $signed({1'b0, cfg.setpoint}) - $signed({1'b0, angle_r});
  assign pb0 = cfg.b0 * e0;
  assign pb1 = cfg.b1 * e1_r;
  assign pb2 = cfg.b2 * e2_r;
  assign fwd = FWD_W'(pb0) + FWD_W'(pb1) + FWD_W'(pb2);

  assign pa1 = coeff_mul_y(cfg.a1, y1_r);
  assign pa2 = coeff_mul_y(cfg.a2, y2_r);
  assign fb  = FB_W'(pa1) + FB_W'(pa2);

  // negate before the shift so the feedback is floored after negation
  assign tot = ((-ACC_W'(fb)) >>> COEFF_FRAC_BITS) + ACC_W'(fwd);

  always_comb begin
    if (tot[ACC_W-1]) begin
      if (&tot[ACC_W-1:Y_W-1]) y_nxt = tot[Y_W-1:0];
      else                     y_nxt = Y_MIN;
    end else begin
      if (|tot[ACC_W-1:Y_W-1]) y_nxt = Y_MAX;
      else                     y_nxt = tot[Y_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      y_valid_r  <= 1'b0;
      e1_r       <= '0;
      e2_r       <= '0;
      y1_r       <= '0;
      y2_r       <= '0;
    end else begin
      if (en_in) begin
        in_valid_r <= in_valid;
      end
      if (en_y) begin
        y_valid_r <= in_valid_r;
        if (in_valid_r) begin
          e2_r <= e1_r;
          e1_r <= e0;
          y2_r <= y1_r;
          y1_r <= y_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_in && in_valid) begin
      angle_r <= in_angle;
    end
    if (en_y && in_valid_r) begin
      y_r <= y_nxt;
    end
  end

  assign y_valid = y_valid_r;
  assign y_value = y_r;

endmodule

// ----- sv/pfd_duty_map.sv -----
// ----------------------------------------------------------------------------
// pfd_duty_map
// Direction, truncated control value and PWM duty from the controller
// output; divide by full scale via a reciprocal multiply and one correction.
// ----------------------------------------------------------------------------
module pfd_duty_map import pfd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfg_t                   cfg,
  input  logic                   y_valid,
  output logic                   y_ready,
  input  logic signed [Y_W-1:0]  y_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output dir_t                   out_direction,
  output logic [PWM_W-1:0]       out_duty,
  output logic signed [CV_W-1:0] out_control_value
);

  // product stage
  logic                   a_valid_r;
  dir_t                   a_dir_r;
  logic signed [CV_W-1:0] a_cv_r;
  logic                   a_neg_r;
  logic [MAP_X_W-1:0]     a_x_r;
  // reciprocal stage
  logic                   b_valid_r;
  dir_t                   b_dir_r;
  logic signed [CV_W-1:0] b_cv_r;
  logic                   b_neg_r;
  logic [MAP_X_W-1:0]     b_x_r;
  logic [PWM_W-1:0]       b_q0_r;
  // result register
  logic                   o_valid_r;
  dir_t                   o_dir_r;
  logic [PWM_W-1:0]       o_duty_r;
  logic signed [CV_W-1:0] o_cv_r;

  logic en_a, en_b, en_o;

  dir_t                     dir_nxt;
  logic signed [IP_W-1:0]   ip;
  logic [IP_W-1:0]          ip_abs;
  logic [DUTY_W-1:0]        mag;
  logic signed [CV_W-1:0]   cv_nxt;
  logic signed [DIFF_W-1:0] diff;
  logic [PWM_W-1:0]         diff_abs;
  logic [MAP_X_W-1:0]       x_nxt;
  logic [MAP_X_W+RECIP_W-1:0] recip_prod;
  logic [MAP_X_W-1:0]       rem;
  logic [PWM_W-1:0]         q;
  logic [PWM_W-1:0]         duty_nxt;

  assign en_o    = !o_valid_r || out_ready;
  assign en_b    = !b_valid_r || en_o;
  assign en_a    = !a_valid_r || en_b;
  assign y_ready = en_a;

  // truncate toward zero: bias negative values before the arithmetic shift
  assign ip = (IP_W'(y_value) + (y_value[Y_W-1] ? IP_W'((1 << COEFF_FRAC_BITS) - 1)
                                                : IP_W'(0))) >>> COEFF_FRAC_BITS;
  assign ip_abs = ip[IP_W-1] ? IP_W'(-ip) : IP_W'(ip);
  assign mag = (ip_abs > IP_W'(DUTY_FULL_SCALE)) ? DUTY_W'(DUTY_FULL_SCALE)
                                                 : ip_abs[DUTY_W-1:0];

  always_comb begin
    if (ip > IP_W'($signed({1'b0, {(CV_W-1){1'b1}}}))) begin
      cv_nxt = {1'b0, {(CV_W-1){1'b1}}};
    end else if (ip < -IP_W'($signed({1'b0, 1'b1, {(CV_W-1){1'b0}}}))) begin
      cv_nxt = {1'b1, {(CV_W-1){1'b0}}};
    end else begin
      cv_nxt = ip[CV_W-1:0];
    end
  end

  always_comb begin
    if (y_value[Y_W-1])     dir_nxt = DIR_CCW;
    else if (|y_value)      dir_nxt = DIR_CW;
    else                    dir_nxt = DIR_KEEP;
  end

  assign diff     = $signed({1'b0, cfg.pwm_max}) - $signed({1'b0, cfg.pwm_min});
  assign diff_abs = diff[DIFF_W-1] ? PWM_W'(-diff) : diff[PWM_W-1:0];
  assign x_nxt    = MAP_X_W'(mag) * MAP_X_W'(diff_abs);

  // q0 is the quotient or one below it
  assign recip_prod = (MAP_X_W+RECIP_W)'(a_x_r) * (MAP_X_W+RECIP_W)'(DUTY_RECIP);

  assign rem = b_x_r - MAP_X_W'(b_q0_r) * MAP_X_W'(DUTY_FULL_SCALE);
  assign q   = (rem >= MAP_X_W'(DUTY_FULL_SCALE)) ? b_q0_r + PWM_W'(1) : b_q0_r;
  assign duty_nxt = b_neg_r ? cfg.pwm_min - q : cfg.pwm_min + q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (en_a) a_valid_r <= y_valid;
      if (en_b) b_valid_r <= a_valid_r;
      if (en_o) o_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && y_valid) begin
      a_dir_r <= dir_nxt;
      a_cv_r  <= cv_nxt;
      a_neg_r <= diff[DIFF_W-1];
      a_x_r   <= x_nxt;
    end
    if (en_b && a_valid_r) begin
      b_dir_r <= a_dir_r;
      b_cv_r  <= a_cv_r;
      b_neg_r <= a_neg_r;
      b_x_r   <= a_x_r;
      b_q0_r  <= recip_prod[MAP_X_W+PWM_W-1:MAP_X_W];
    end
    if (en_o && b_valid_r) begin
      o_dir_r  <= b_dir_r;
      o_cv_r   <= b_cv_r;
      o_duty_r <= duty_nxt;
    end
  end

  assign out_valid         = o_valid_r;
  assign out_direction     = o_dir_r;
  assign out_duty          = o_duty_r;
  assign out_control_value = o_cv_r;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the filtered-derivative PID motor drive. A short
// directed plan covers reset gains, angle extremes, truncation toward zero,
// an inverted pwm range and accumulator saturation. Random phases follow,
// each under new register settings. Every result transfer is checked against
// a pinned word or the in-bench model of the difference equation and duty map.
// ----------------------------------------------------------------------------
module tb;
  import pfd_pkg::*;

  localparam int TOTAL_SAMPLES = 750;
  localparam int DRAIN_CYCLES  = 20;
  localparam int ANGLE_TOP     = (1 << ANGLE_W) - 1;

  typedef struct packed {
    dir_t                   direction;
    logic [PWM_W-1:0]       duty;
    logic signed [CV_W-1:0] control_value;
  } drive_word_t;

  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_SAMPLE,
    ROW_KNOWN
  } row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    reg_idx_t              idx;
    logic [CFG_DATA_W-1:0] data;
    logic [ANGLE_W-1:0]    angle;
    drive_word_t           known;
  } plan_row_t;

  typedef enum int {
    MODE_DEFAULT,
    MODE_GENTLE,
    MODE_EXTREME,
    MODE_WILD
  } setting_mode_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [REG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  pfd_in_if  in_ch ();
  pfd_out_if out_ch ();

  pid_filtered_derivative_motor_drive_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // model copy of the registers and the delay lines
  cfg_t                    drive_cfg;
  logic signed [ERR_W-1:0] err_d1, err_d2;
  logic signed [Y_W-1:0]   out_d1, out_d2;

  drive_word_t pending_words[$];
  plan_row_t   plan[$];
  int          mismatches;
  int          samples_sent;
  int          feed_calm;
  int          drain_calm;
  int          walk_angle;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("pid_filtered_derivative_motor_drive_top: mismatch");
    $finish;
  end

  // mostly back to back, some short gaps, a few long ones, and calm stretches
  function automatic int next_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r == 0) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // one sample tick: returns the drive word and shifts the delay lines
  function automatic drive_word_t advance_drive(input logic [ANGLE_W-1:0] angle);
    drive_word_t         w;
    longint              sp, an, err_now, e1, e2, c0, c1, c2;
    longint              fwd, y, ip, mag, pmin, pmax, duty;
    logic signed [127:0] fa1, fa2, fy1, fy2, ffwd, fb, tot;
    sp      = longint'(drive_cfg.setpoint);
    an      = longint'(angle);
    err_now = sp - an;
    e1      = longint'(err_d1);
    e2      = longint'(err_d2);
    c0      = longint'(drive_cfg.b0);
    c1      = longint'(drive_cfg.b1);
    c2      = longint'(drive_cfg.b2);
    fwd     = c0 * err_now + c1 * e1 + c2 * e2;
    fa1     = 128'(drive_cfg.a1);
    fa2     = 128'(drive_cfg.a2);
    fy1     = 128'(out_d1);
    fy2     = 128'(out_d2);
    ffwd    = 128'(fwd);
    fb      = fa1 * fy1 + fa2 * fy2;
    // feedback is floored, the feed-forward terms are exact
    tot     = ((-fb) >>> COEFF_FRAC_BITS) + ffwd;
    if (tot > Y_MAX) y = longint'(Y_MAX);
    else if (tot < Y_MIN) y = longint'(Y_MIN);
    else y = tot[63:0];

    if (y >= 0) ip = y >>> COEFF_FRAC_BITS;
    else ip = -((-y) >>> COEFF_FRAC_BITS);
    w.direction = (y > 0) ? DIR_CW : (y < 0) ? DIR_CCW : DIR_KEEP;

    mag = (ip < 0) ? -ip : ip;
    if (mag > DUTY_FULL_SCALE) mag = DUTY_FULL_SCALE;
    pmin = longint'(drive_cfg.pwm_min);
    pmax = longint'(drive_cfg.pwm_max);
    duty = mag * (pmax - pmin) / DUTY_FULL_SCALE + pmin;
    w.duty = duty[PWM_W-1:0];

    if (ip > 64'sd2147483647) ip = 64'sd2147483647;
    if (ip < -64'sd2147483648) ip = -64'sd2147483648;
    w.control_value = ip[CV_W-1:0];

    err_d2 = err_d1;
    err_d1 = err_now[ERR_W-1:0];
    out_d2 = out_d1;
    out_d1 = y[Y_W-1:0];
    return w;
  endfunction

  function automatic plan_row_t reg_row(input reg_idx_t idx,
                                        input logic [CFG_DATA_W-1:0] data);
    plan_row_t r;
    r      = '0;
    r.kind = ROW_WRITE;
    r.idx  = idx;
    r.data = data;
    return r;
  endfunction

  function automatic plan_row_t angle_row(input logic [ANGLE_W-1:0] angle);
    plan_row_t r;
    r       = '0;
    r.kind  = ROW_SAMPLE;
    r.angle = angle;
    return r;
  endfunction

  function automatic plan_row_t pinned_row(input logic [ANGLE_W-1:0] angle,
                                           input dir_t dir,
                                           input logic [PWM_W-1:0] duty,
                                           input logic signed [CV_W-1:0] cv);
    plan_row_t r;
    r                     = '0;
    r.kind                = ROW_KNOWN;
    r.angle               = angle;
    r.known.direction     = dir;
    r.known.duty          = duty;
    r.known.control_value = cv;
    return r;
  endfunction

  function automatic logic [ANGLE_W-1:0] pick_angle();
    int r, a;
    r = $urandom_range(0, 99);
    // a slowly wandering pendulum for 40 percent of ticks, plus jumps and extremes
    if (r < 40) a = walk_angle + $urandom_range(0, 10) - 5;
    else if (r < 65) a = $urandom_range(0, 359);
    else if (r < 80) a = int'(drive_cfg.setpoint) + $urandom_range(0, 6) - 3;
    else if (r < 92) a = $urandom_range(360, ANGLE_TOP);
    else a = (r < 96) ? 0 : ANGLE_TOP;
    if (a < 0) a = 0;
    if (a > ANGLE_TOP) a = ANGLE_TOP;
    walk_angle = a;
    return a[ANGLE_W-1:0];
  endfunction

  function automatic logic [COEFF_W-1:0] pick_coeff(input setting_mode_t mode,
                                                   input logic [COEFF_W-1:0] dflt,
                                                   input int span);
    int v;
    case (mode)
      MODE_DEFAULT: return dflt;
      MODE_GENTLE: begin
        v = int'($urandom_range(0, 2 * span)) - span;
        return v;
      end
      MODE_EXTREME: begin
        case ($urandom_range(0, 4))
          0:       return 32'h7fff_ffff;
          1:       return 32'h8000_0000;
          2:       return 32'h0000_0000;
          3:       return 32'h0001_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_wdata <= data;
    cfg_we    <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_SETPOINT: drive_cfg.setpoint = data[ANGLE_W-1:0];
      REG_COEFF_B0: drive_cfg.b0       = data;
      REG_COEFF_B1: drive_cfg.b1       = data;
      REG_COEFF_B2: drive_cfg.b2       = data;
      REG_COEFF_A1: drive_cfg.a1       = data;
      REG_COEFF_A2: drive_cfg.a2       = data;
      REG_PWM_MIN:  drive_cfg.pwm_min  = data[PWM_W-1:0];
      REG_PWM_MAX:  drive_cfg.pwm_max  = data[PWM_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // registers only change once every result has drained
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  task automatic send_angle(input logic [ANGLE_W-1:0] angle, input bit pinned,
                            input drive_word_t known);
    int          gap;
    drive_word_t want;
    gap = next_gap(feed_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.angle <= angle;
    do @(posedge clk); while (!in_ch.ready);
    want = advance_drive(angle);
    pending_words.push_back(pinned ? known : want);
    samples_sent++;
  endtask

  task automatic load_drive_settings(input setting_mode_t mode);
    logic [ANGLE_W-1:0] sp;
    logic [PWM_W-1:0]   pmin, pmax;
    settle_block();
    case ($urandom_range(0, 5))
      0:       sp = '0;
      1:       sp = 9'd359;
      2:       sp = ANGLE_W'(ANGLE_TOP);
      default: sp = ANGLE_W'($urandom_range(0, ANGLE_TOP));
    endcase
    case ($urandom_range(0, 5))
      0: begin
        pmin = 12'd0;
        pmax = 12'd4095;
      end
      1: begin
        pmin = 12'd4095;
        pmax = 12'd0;
      end
      2: begin
        pmin = PWM_MIN_RST;
        pmax = PWM_MAX_RST;
      end
      default: begin
        pmin = PWM_W'($urandom);
        pmax = PWM_W'($urandom);
      end
    endcase
    write_reg(REG_SETPOINT, CFG_DATA_W'(sp));
    // gentle spans: b up to 8.0, a1 0.6, a2 0.3 in Q16.16 - a stable filter
    write_reg(REG_COEFF_B0, pick_coeff(mode, COEFF_B0_RST, 524288));
    write_reg(REG_COEFF_B1, pick_coeff(mode, COEFF_B1_RST, 524288));
    write_reg(REG_COEFF_B2, pick_coeff(mode, COEFF_B2_RST, 524288));
    write_reg(REG_COEFF_A1, pick_coeff(mode, COEFF_A1_RST, 39322));
    write_reg(REG_COEFF_A2, pick_coeff(mode, COEFF_A2_RST, 19661));
    write_reg(REG_PWM_MIN, CFG_DATA_W'(pmin));
    write_reg(REG_PWM_MAX, CFG_DATA_W'(pmax));
  endtask

  initial begin : result_pacing
    int run, gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      run = $urandom_range(1, 12);
      out_ch.ready <= 1'b1;
      repeat (run) @(posedge clk);
      gap = next_gap(drain_calm);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    drive_word_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.direction     = out_ch.direction;
      got.duty          = out_ch.duty;
      got.control_value = out_ch.control_value;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transfer: dir %0d duty %0d cv %0d",
                   got.direction, got.duty, $signed(got.control_value));
      end else begin
        want = pending_words.pop_front();
        if (got.direction !== want.direction || got.duty !== want.duty ||
            got.control_value !== want.control_value) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"drive word wrong: expected dir %0d duty %0d cv %0d, ",
                      "got dir %0d duty %0d cv %0d"},
                     want.direction, want.duty, $signed(want.control_value),
                     got.direction, got.duty, $signed(got.control_value));
        end
      end
    end
  end

  initial begin : stimulus
    bit            in_flight;
    int            phase, run;
    setting_mode_t mode;
    in_ch.valid  <= 1'b0;
    in_ch.angle  <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_SETPOINT;
    cfg_wdata    <= '0;
    rst_n        <= 1'b0;
    mismatches   = 0;
    samples_sent = 0;
    feed_calm    = 0;
    drain_calm   = 0;
    walk_angle   = 150;
    in_flight    = 1'b0;
    drive_cfg    = '{SETPOINT_RST, COEFF_B0_RST, COEFF_B1_RST, COEFF_B2_RST,
                     COEFF_A1_RST, COEFF_A2_RST, PWM_MIN_RST, PWM_MAX_RST};
    err_d1 = '0;
    err_d2 = '0;
    out_d1 = '0;
    out_d2 = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset gains: angle on target gives zero drive
    plan.push_back(pinned_row(9'd150, DIR_KEEP, 12'd2457, 32'sd0));
    plan.push_back(pinned_row(9'd150, DIR_KEEP, 12'd2457, 32'sd0));
    plan.push_back(angle_row(9'd0));
    plan.push_back(angle_row(9'd359));
    plan.push_back(angle_row(9'd511));
    plan.push_back(angle_row(9'd150));
    plan.push_back(angle_row(9'd149));
    // unity proportional gain, full pwm range
    plan.push_back(reg_row(REG_SETPOINT, 32'd0));
    plan.push_back(reg_row(REG_COEFF_B0, 32'h0001_0000));
    plan.push_back(reg_row(REG_COEFF_B1, 32'd0));
    plan.push_back(reg_row(REG_COEFF_B2, 32'd0));
    plan.push_back(reg_row(REG_COEFF_A1, 32'd0));
    plan.push_back(reg_row(REG_COEFF_A2, 32'd0));
    plan.push_back(reg_row(REG_PWM_MIN, 32'd0));
    plan.push_back(reg_row(REG_PWM_MAX, 32'd4095));
    plan.push_back(pinned_row(9'd0, DIR_KEEP, 12'd0, 32'sd0));
    plan.push_back(pinned_row(9'd100, DIR_CCW, 12'd100, -32'sd100));
    plan.push_back(pinned_row(9'd511, DIR_CCW, 12'd511, -32'sd511));
    plan.push_back(reg_row(REG_SETPOINT, 32'd511));
    plan.push_back(pinned_row(9'd0, DIR_CW, 12'd511, 32'sd511));
    plan.push_back(pinned_row(9'd511, DIR_KEEP, 12'd0, 32'sd0));
    // half gain: -1.5 must truncate to -1, not floor to -2
    plan.push_back(reg_row(REG_COEFF_B0, 32'h0000_8000));
    plan.push_back(reg_row(REG_SETPOINT, 32'd0));
    plan.push_back(pinned_row(9'd3, DIR_CCW, 12'd1, -32'sd1));
    // inverted pwm range maps downward
    plan.push_back(reg_row(REG_COEFF_B0, 32'h0001_0000));
    plan.push_back(reg_row(REG_SETPOINT, 32'd511));
    plan.push_back(reg_row(REG_PWM_MIN, 32'd4095));
    plan.push_back(reg_row(REG_PWM_MAX, 32'd0));
    plan.push_back(pinned_row(9'd511, DIR_KEEP, 12'd4095, 32'sd0));
    plan.push_back(pinned_row(9'd0, DIR_CW, 12'd3584, 32'sd511));
    // runaway feedback drives the accumulator into saturation
    plan.push_back(reg_row(REG_COEFF_B0, 32'h7fff_ffff));
    plan.push_back(reg_row(REG_COEFF_A1, 32'h8000_0000));
    plan.push_back(reg_row(REG_COEFF_A2, 32'h7fff_ffff));
    plan.push_back(reg_row(REG_PWM_MIN, 32'd0));
    plan.push_back(reg_row(REG_PWM_MAX, 32'd4095));
    repeat (5) plan.push_back(angle_row(9'd0));
    plan.push_back(reg_row(REG_COEFF_B0, 32'h8000_0000));
    plan.push_back(reg_row(REG_COEFF_B1, 32'h7fff_ffff));
    plan.push_back(reg_row(REG_COEFF_B2, 32'h8000_0000));
    plan.push_back(reg_row(REG_COEFF_A1, 32'h7fff_ffff));
    plan.push_back(reg_row(REG_COEFF_A2, 32'h8000_0000));
    plan.push_back(angle_row(9'd511));
    plan.push_back(angle_row(9'd0));
    plan.push_back(angle_row(9'd511));
    plan.push_back(angle_row(9'd0));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        if (in_flight) settle_block();
        in_flight = 1'b0;
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_angle(plan[i].angle, plan[i].kind == ROW_KNOWN, plan[i].known);
        in_flight = 1'b1;
      end
    end

    phase = 0;
    while (samples_sent < TOTAL_SAMPLES) begin
      mode = (phase < 4) ? setting_mode_t'(phase) : setting_mode_t'($urandom_range(0, 3));
      load_drive_settings(mode);
      run = $urandom_range(50, 100);
      repeat (run) send_angle(pick_angle(), 1'b0, '0);
      phase++;
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("pid_filtered_derivative_motor_drive_top: match");
    end else begin
      $display("pid_filtered_derivative_motor_drive_top: mismatch");
    end
    $finish;
  end

endmodule

// ----- pid_filtered_derivative_motor_drive_top.f -----
sv/pfd_pkg.sv
sv/pfd_if.sv
sv/pfd_cfg_regs.sv
sv/pfd_loop.sv
sv/pfd_duty_map.sv
sv/pid_filtered_derivative_motor_drive_top.sv
tb/tb.sv
